// ----- rtl/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int PRIO_PORT_W   = 8;
  localparam int CLIENT_W      = 32;
  localparam int ITEMS_W       = 16;
  localparam int OCC_W         = 5;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [CLIENT_W-1:0]      client;
    logic [ITEMS_W-1:0]       items;
  } entry_t;

  typedef struct packed {
    logic   en;
    logic   deq;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds, shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occ,
  input  wire entry_t     left_entry,
  input  wire logic       left_gt,
  input  wire entry_t     right_entry,
  output entry_t          entry,
  output logic            gt
);

  entry_t entry_next;

  // strictly greater keeps ties in arrival order
  assign gt = !occ || (entry.prio > ctrl.new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.en) begin
      if (ctrl.deq) begin
        entry_next = right_entry;
      end else if (gt) begin
        entry_next = left_gt ? left_entry : ctrl.new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

// ----- rtl/stable_priority_queue_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded sorted priority queue built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Takes one enqueue or dequeue beat per clock unless the input stalls; its
// result appears in the output register in the cycle after acceptance. Every
// cell of the chain compares its slot with the incoming priority and shifts
// in the same cycle. Input stalls only while a finished result is held and
// the output side stalls. Equal priorities leave in arrival order; an
// enqueue on a full queue is dropped with a full status, a dequeue on an
// empty queue returns an empty status.
// ----------------------------------------------------------------------------
module stable_priority_queue_top import spq_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   kind,
  input  wire logic [PRIO_PORT_W-1:0] priority_req,
  input  wire logic [CLIENT_W-1:0]    client_handle,
  input  wire logic [ITEMS_W-1:0]     item_count,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  status,
  output logic [PRIO_PORT_W-1:0]      out_priority,
  output logic [CLIENT_W-1:0]         out_client_handle,
  output logic [ITEMS_W-1:0]          out_item_count,
  output logic [OCC_W-1:0]            occupancy
);

  logic               accept;
  logic               is_deq;
  logic               full;
  logic               empty;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  cell_ctrl_t         ctrl;
  entry_t             entries [QUEUE_DEPTH];
  logic               gts [QUEUE_DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_deq   = (kind == KIND_DEQ);
  assign full     = (count == COUNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    ctrl.en                   = accept && (is_deq ? !empty : !full);
    ctrl.deq                  = is_deq;
    ctrl.new_entry.prio       = priority_req[PRIORITY_BITS-1:0];
    ctrl.new_entry.client     = client_handle;
    ctrl.new_entry.items      = item_count;
    count_next = count;
    if (ctrl.en) begin
      count_next = is_deq ? count - 1'b1 : count + 1'b1;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_g;
    if (i == 0) begin : g_head
      assign left_e = ctrl.new_entry;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_e = entries[i-1];
      assign left_g = gts[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (COUNT_W'(i) < count),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .entry       (entries[i]),
      .gt          (gts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy         <= OCC_W'(count_next);
      out_priority      <= '0;
      out_client_handle <= '0;
      out_item_count    <= '0;
      if (is_deq) begin
        if (empty) begin
          status <= STATUS_EMPTY;
        end else begin
          status            <= STATUS_OK;
          out_priority      <= PRIO_PORT_W'(entries[0].prio);
          out_client_handle <= entries[0].client;
          out_item_count    <= entries[0].items;
        end
      end else begin
        status <= full ? STATUS_FULL : STATUS_OK;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("stored count above depth");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    accept && is_deq && !empty |=> count == $past(count) - 1'b1)
    else $error("dequeue did not drop count by one");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> occupancy == OCC_W'(QUEUE_DEPTH))
    else $error("full status with queue not full");

  a_result_after_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

endmodule
`default_nettype wire

// ----- sim/tb_stable_priority_queue_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue_top
// Self-checking bench for the stable sorted priority queue.
// ----------------------------------------------------------------------------
// Mirrors the sorted slot array in a local model, predicts status, removed
// entry and occupancy for every accepted beat, and compares each output beat
// against the oldest prediction. Covers empty dequeue, fill to full with
// a dropped enqueue, tie ordering, long random mixes with random idling on
// both sides, a long output hold that backs up the input, and a full-rate run.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue_top;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    status_t                 status;
    logic [PRIO_PORT_W-1:0]  prio;
    logic [CLIENT_W-1:0]     client;
    logic [ITEMS_W-1:0]      items;
    logic [OCC_W-1:0]        occ;
  } queue_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   kind = 1'b0;
  logic [PRIO_PORT_W-1:0] priority_req = '0;
  logic [CLIENT_W-1:0]    client_handle = '0;
  logic [ITEMS_W-1:0]     item_count = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             status;
  logic [PRIO_PORT_W-1:0] out_priority;
  logic [CLIENT_W-1:0]    out_client_handle;
  logic [ITEMS_W-1:0]     out_item_count;
  logic [OCC_W-1:0]       occupancy;

  // local copy of the slot chain
  entry_t        model_slots [QUEUE_DEPTH];
  int            model_count = 0;
  queue_result_t pending_results [$];

  int gap_pct = 25;
  int stall_pct = 25;
  int hold_cycles = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int empty_seen = 0;
  int full_seen = 0;
  int peak_occ = 0;
  int input_stall_cycles = 0;

  stable_priority_queue_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .kind              (kind),
    .priority_req      (priority_req),
    .client_handle     (client_handle),
    .item_count        (item_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .out_priority      (out_priority),
    .out_client_handle (out_client_handle),
    .out_item_count    (out_item_count),
    .occupancy         (occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic queue_result_t apply_queue_op(kind_t op,
                                                   logic [PRIO_PORT_W-1:0] prio_in,
                                                   logic [CLIENT_W-1:0] client,
                                                   logic [ITEMS_W-1:0] items);
    queue_result_t r;
    entry_t        fresh;
    int            pos;
    int            i;
    r.status = STATUS_OK;
    r.prio   = '0;
    r.client = '0;
    r.items  = '0;
    fresh.prio   = prio_in[PRIORITY_BITS-1:0];
    fresh.client = client;
    fresh.items  = items;
    if (op == KIND_ENQ) begin
      if (model_count >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < model_count && model_slots[pos].prio <= fresh.prio) pos++;
        for (i = model_count; i > pos; i--) model_slots[i] = model_slots[i-1];
        model_slots[pos] = fresh;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.prio   = PRIO_PORT_W'(model_slots[0].prio);
        r.client = model_slots[0].client;
        r.items  = model_slots[0].items;
        for (i = 1; i < model_count; i++) model_slots[i-1] = model_slots[i];
        model_count--;
      end
    end
    r.occ = OCC_W'(model_count);
    return r;
  endfunction

  task automatic send_op(kind_t op, logic [PRIO_PORT_W-1:0] prio,
                         logic [CLIENT_W-1:0] client, logic [ITEMS_W-1:0] items);
    int gap;
    gap = 0;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) gap = $urandom_range(7, 1);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= op;
    priority_req  <= prio;
    client_handle <= client;
    item_count    <= items;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_queue_op(op, prio, client, items));
    ops_sent++;
  endtask

  function automatic logic [PRIO_PORT_W-1:0] pick_priority();
    case ($urandom_range(3))
      0: return PRIO_PORT_W'($urandom_range(3));
      1: return PRIO_PORT_W'($urandom);
      2: return $urandom_range(1) ? '1 : '0;
      default: return PRIO_PORT_W'($urandom_range(103, 100));
    endcase
  endfunction

  task automatic send_random_op(int enq_pct);
    if ($urandom_range(99) < enq_pct)
      send_op(KIND_ENQ, pick_priority(), $urandom, ITEMS_W'($urandom));
    else
      send_op(KIND_DEQ, PRIO_PORT_W'($urandom), $urandom, ITEMS_W'($urandom));
  endtask

  // receiver: random stall bursts, or one long hold on request
  always begin
    @(negedge clk);
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      repeat (hold_cycles) @(negedge clk);
      hold_cycles = 0;
      out_stall <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(7, 1)) @(negedge clk);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && in_valid && in_stall) input_stall_cycles++;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no pending prediction");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (out_priority !== want.prio) begin
          $error("out_priority: expected %0h, got %0h", want.prio, out_priority);
          fail_count++;
        end
        if (out_client_handle !== want.client) begin
          $error("out_client_handle: expected %0h, got %0h", want.client,
                 out_client_handle);
          fail_count++;
        end
        if (out_item_count !== want.items) begin
          $error("out_item_count: expected %0h, got %0h", want.items, out_item_count);
          fail_count++;
        end
        if (occupancy !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
          fail_count++;
        end
        if (want.status == STATUS_EMPTY) empty_seen++;
        if (want.status == STATUS_FULL) full_seen++;
        if (int'(want.occ) > peak_occ) peak_occ = want.occ;
      end
    end
  end

  task automatic test_empty_dequeue();
    send_op(KIND_DEQ, '1, '1, '1);
    send_op(KIND_DEQ, '0, '0, '0);
  endtask

  task automatic test_fill_to_full();
    logic [PRIO_PORT_W-1:0] fill_prio [QUEUE_DEPTH] = '{
      8'hFF, 8'h80, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h80, 8'h07,
      8'hC8, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h40, 8'h80};
    logic [CLIENT_W-1:0] client;
    logic [ITEMS_W-1:0]  items;
    int i;
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      client = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
      items  = (i == 0) ? '0 : (i % 2 == 1) ? '1 : ITEMS_W'($urandom);
      send_op(KIND_ENQ, fill_prio[i], client, items);
    end
    // lowest priority on a full queue must still be dropped
    send_op(KIND_ENQ, '0, 32'hDEAD_0001, 16'h5A5A);
  endtask

  task automatic test_tie_order();
    int i;
    for (i = 0; i < 4; i++) send_op(KIND_DEQ, '0, '0, '0);
  endtask

  task automatic test_random_mix();
    int enq_mix [8] = '{80, 20, 55, 90, 10, 50, 70, 30};
    int p;
    int n;
    for (p = 0; p < 8; p++)
      for (n = 0; n < 100; n++) send_random_op(enq_mix[p]);
  endtask

  task automatic test_output_backpressure();
    int n;
    gap_pct = 0;
    hold_cycles = 60;
    for (n = 0; n < 30; n++) send_random_op(60);
    gap_pct = 25;
  endtask

  task automatic test_full_rate();
    int n;
    gap_pct = 0;
    stall_pct = 0;
    for (n = 0; n < 100; n++) send_random_op(50);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_empty_dequeue();
    test_fill_to_full();
    test_tie_order();
    test_random_mix();
    test_output_backpressure();
    test_full_rate();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Ran %0d operations, checked %0d results: %0d empty dequeues, %0d full drops,",
             ops_sent, results_seen, empty_seen, full_seen);
    $display("peak occupancy %0d, %0d cycles with the input held off.",
             peak_occ, input_stall_cycles);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_top.sv
sim/tb_stable_priority_queue_top.sv
